// ----- design/bvg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_pkg
// Shared types and constants of the battery voltage gauge.
// ----------------------------------------------------------------------------
package bvg_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int MV_W       = 17;
	localparam int CHARGE_W   = 14;
	localparam int RES_W      = 20;
	localparam int CELL_W     = 5;
	localparam int CELL_MV_W  = 13;
	localparam int SPAN_W     = 16;
	localparam int PROD_W     = MV_W + CHARGE_W;
	localparam int QUO_W      = MV_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 20;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ENABLED = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_UPPER   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LOWER   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CHEM    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CELLS   = 3'd4;

	localparam logic CHEM_LIPO = 1'b0;
	localparam logic CHEM_LFP  = 1'b1;

	localparam logic [CELL_MV_W-1:0] LIPO_FULL_MV  = 13'd4200;
	localparam logic [CELL_MV_W-1:0] LIPO_EMPTY_MV = 13'd3000;
	localparam logic [CELL_MV_W-1:0] LFP_FULL_MV   = 13'd3650;
	localparam logic [CELL_MV_W-1:0] LFP_EMPTY_MV  = 13'd2500;
	localparam logic [CELL_MV_W-1:0] LIPO_SPAN_MV  = LIPO_FULL_MV - LIPO_EMPTY_MV;
	localparam logic [CELL_MV_W-1:0] LFP_SPAN_MV   = LFP_FULL_MV - LFP_EMPTY_MV;

	localparam logic [MV_W-1:0]     MV_MAX      = 17'd131071;
	localparam logic [CHARGE_W-1:0] CHARGE_FULL = 14'd10000;

	localparam logic [RES_W-1:0]  UPPER_RESET = 20'd100000;
	localparam logic [RES_W-1:0]  LOWER_RESET = 20'd100000;
	localparam logic [CELL_W-1:0] CELLS_RESET = 5'd1;

	typedef struct packed {
		logic              enabled;
		logic [RES_W-1:0]  upper_ohms;
		logic [RES_W-1:0]  lower_ohms;
		logic              chemistry;
		logic [CELL_W-1:0] cell_count;
	} bvg_cfg_t;

endpackage

// ----- design/bvg_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bvg_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/bvg_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_front
// Takes readings, keeps the sample ring and running sum, queues the sum.
// ----------------------------------------------------------------------------
module bvg_front #(
	parameter int AVERAGE_DEPTH = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  bvg_pkg::bvg_cfg_t       cfg,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [bvg_pkg::SAMPLE_W-1:0] sample_mv,
	input  logic                    q_full,
	output logic                    q_push,
	output logic [$clog2(AVERAGE_DEPTH*(2**bvg_pkg::SAMPLE_W-1)+1):0] q_data
);

	localparam int IDX_W = $clog2(AVERAGE_DEPTH);
	localparam int SUM_W = $clog2(AVERAGE_DEPTH*(2**bvg_pkg::SAMPLE_W-1)+1);

	logic                         accept;
	logic                         busy_s1;
	logic                         zero_s1;
	logic [bvg_pkg::SAMPLE_W-1:0] sample_s1;
	logic [IDX_W-1:0]             idx_q;
	logic                         wrapped_q;
	logic [SUM_W-1:0]             sum_q;
	logic [bvg_pkg::SAMPLE_W-1:0] rdata;
	logic [bvg_pkg::SAMPLE_W-1:0] oldest;
	logic [SUM_W-1:0]             sum_next;
	logic                         update;
	logic                         idx_last;

	// one item in flight here; the queue cannot fill behind an accepted beat
	assign in_ready = ~busy_s1 & ~q_full;
	assign accept   = in_valid & in_ready;

	bvg_ram #(
		.WIDTH(bvg_pkg::SAMPLE_W),
		.DEPTH(AVERAGE_DEPTH)
	) u_ring (
		.clk  (clk),
		.we   (update),
		.waddr(idx_q),
		.wdata(sample_s1),
		.re   (accept & cfg.enabled),
		.raddr(idx_q),
		.rdata(rdata)
	);

	// entries are written in index order, so before the first wrap the slot
	// about to be overwritten has never been written and is read as zero
	assign oldest   = wrapped_q ? rdata : '0;
	assign sum_next = sum_q - SUM_W'(oldest) + SUM_W'(sample_s1);
	assign update   = busy_s1 & ~zero_s1;
	assign idx_last = (idx_q == IDX_W'(AVERAGE_DEPTH - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_s1   <= 1'b0;
			idx_q     <= '0;
			wrapped_q <= 1'b0;
			sum_q     <= '0;
		end else begin
			busy_s1 <= accept;
			if (update) begin
				sum_q <= sum_next;
				if (idx_last) begin
					idx_q     <= '0;
					wrapped_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			zero_s1   <= ~cfg.enabled;
			sample_s1 <= sample_mv;
		end
	end

	assign q_push = busy_s1;
	assign q_data = {zero_s1, sum_next};

endmodule

// ----- design/bvg_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module bvg_queue #(
	parameter int WIDTH = 17
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             empty
);

	localparam int PTR_W = $clog2(bvg_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(bvg_pkg::QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [bvg_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(bvg_pkg::QUEUE_DEPTH));
	assign empty    = (count_q == '0);
	assign do_push  = push & ~full;
	assign do_pop   = pop & ~empty;
	assign pop_data = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

// ----- design/bvg_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_div
// Restoring divider, one quotient bit per cycle; quotient must fit QUO_W bits.
// ----------------------------------------------------------------------------
module bvg_div #(
	parameter int NUM_W = 35,
	parameter int DEN_W = 24
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [NUM_W-1:0]           num,
	input  logic [DEN_W-1:0]           den,
	output logic                       done,
	output logic [bvg_pkg::QUO_W-1:0]  quotient
);

	localparam int QW    = bvg_pkg::QUO_W;
	localparam int SH_W  = DEN_W + QW - 1;
	localparam int CMP_W = (NUM_W > SH_W) ? NUM_W : SH_W;
	localparam int CNT_W = $clog2(QW + 1);

	logic [CMP_W-1:0] rem_q;
	logic [CMP_W-1:0] dsh_q;
	logic [QW-1:0]    quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             ge;

	assign ge = (rem_q >= dsh_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(QW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CMP_W'(num);
			dsh_q <= CMP_W'({den, {(QW-1){1'b0}}});
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[QW-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- design/bvg_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvg_back
// Scales the running sum to pack millivolts and maps it to state of charge.
// ----------------------------------------------------------------------------
module bvg_back #(
	parameter int AVERAGE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bvg_pkg::bvg_cfg_t             cfg,
	input  logic                          q_empty,
	output logic                          q_pop,
	input  logic [$clog2(AVERAGE_DEPTH*(2**bvg_pkg::SAMPLE_W-1)+1):0] q_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [bvg_pkg::MV_W-1:0]      battery_mv,
	output logic [bvg_pkg::CHARGE_W-1:0]  charge_centipercent
);

	localparam int SUM_W = $clog2(AVERAGE_DEPTH*(2**bvg_pkg::SAMPLE_W-1)+1);
	localparam int IDX_W = $clog2(AVERAGE_DEPTH);
	localparam int DEN_W = bvg_pkg::RES_W + IDX_W;
	localparam int NUM_W = SUM_W + bvg_pkg::RES_W + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_MUL  = 4'd1;
	localparam logic [3:0] ST_CHK  = 4'd2;
	localparam logic [3:0] ST_DIVV = 4'd3;
	localparam logic [3:0] ST_CHG  = 4'd4;
	localparam logic [3:0] ST_DEC  = 4'd5;
	localparam logic [3:0] ST_CST  = 4'd6;
	localparam logic [3:0] ST_DIVC = 4'd7;
	localparam logic [3:0] ST_DONE = 4'd8;

	logic [3:0]                      st_q;
	logic [SUM_W-1:0]                sum_q;
	logic [NUM_W-1:0]                num_q;
	logic [DEN_W-1:0]                den_q;
	logic [bvg_pkg::MV_W-1:0]        mv_q;
	logic [bvg_pkg::CHARGE_W-1:0]    chg_q;
	logic [bvg_pkg::MV_W-1:0]        vmax_q;
	logic [bvg_pkg::MV_W-1:0]        vmin_q;
	logic [bvg_pkg::SPAN_W-1:0]      span_q;
	logic [bvg_pkg::PROD_W-1:0]      prod_q;
	logic                            out_valid_q;
	logic [bvg_pkg::MV_W-1:0]        battery_mv_q;
	logic [bvg_pkg::CHARGE_W-1:0]    charge_q;

	logic [bvg_pkg::RES_W:0]         r_total;
	logic                            saturate;
	logic                            div_start;
	logic [NUM_W-1:0]                div_num;
	logic [DEN_W-1:0]                div_den;
	logic                            div_done;
	logic [bvg_pkg::QUO_W-1:0]       div_quo;
	logic [bvg_pkg::CELL_MV_W-1:0]   full_cell;
	logic [bvg_pkg::CELL_MV_W-1:0]   empty_cell;
	logic [bvg_pkg::CELL_MV_W-1:0]   span_cell;
	logic                            out_free;

	assign r_total  = {1'b0, cfg.upper_ohms} + {1'b0, cfg.lower_ohms};
	// num >= den * 2^QUO_W means the quotient would not fit: saturate.
	// A zero lower resistor lands here too.
	assign saturate = (num_q[NUM_W-1:bvg_pkg::QUO_W] >= NUM_W'(den_q));

	assign full_cell  = (cfg.chemistry == bvg_pkg::CHEM_LFP) ?
		bvg_pkg::LFP_FULL_MV : bvg_pkg::LIPO_FULL_MV;
	assign empty_cell = (cfg.chemistry == bvg_pkg::CHEM_LFP) ?
		bvg_pkg::LFP_EMPTY_MV : bvg_pkg::LIPO_EMPTY_MV;
	assign span_cell  = (cfg.chemistry == bvg_pkg::CHEM_LFP) ?
		bvg_pkg::LFP_SPAN_MV : bvg_pkg::LIPO_SPAN_MV;

	assign div_start = ((st_q == ST_CHK) && !saturate) || (st_q == ST_CST);
	assign div_num   = (st_q == ST_CST) ? NUM_W'(prod_q) : num_q;
	assign div_den   = (st_q == ST_CST) ? DEN_W'(span_q) : den_q;

	bvg_div #(
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.num     (div_num),
		.den     (div_den),
		.done    (div_done),
		.quotient(div_quo)
	);

	assign q_pop    = (st_q == ST_IDLE) & ~q_empty;
	assign out_free = ~out_valid_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			if ((st_q == ST_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						if (q_data[SUM_W] || (q_data[SUM_W-1:0] == '0)) begin
							st_q <= ST_DONE;
						end else begin
							st_q <= ST_MUL;
						end
					end
				end
				ST_MUL: begin
					st_q <= ST_CHK;
				end
				ST_CHK: begin
					st_q <= saturate ? ST_CHG : ST_DIVV;
				end
				ST_DIVV: begin
					if (div_done) begin
						st_q <= ST_CHG;
					end
				end
				ST_CHG: begin
					st_q <= ST_DEC;
				end
				ST_DEC: begin
					if ((mv_q == '0) || (mv_q <= vmin_q) || (mv_q >= vmax_q)) begin
						st_q <= ST_DONE;
					end else begin
						st_q <= ST_CST;
					end
				end
				ST_CST: begin
					st_q <= ST_DIVC;
				end
				ST_DIVC: begin
					if (div_done) begin
						st_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						st_q <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			ST_IDLE: begin
				sum_q <= q_data[SUM_W-1:0];
				mv_q  <= '0;
				chg_q <= '0;
			end
			ST_MUL: begin
				num_q <= NUM_W'(sum_q) * NUM_W'(r_total);
				den_q <= DEN_W'(cfg.lower_ohms) * DEN_W'(AVERAGE_DEPTH);
			end
			ST_CHK: begin
				if (saturate) begin
					mv_q <= bvg_pkg::MV_MAX;
				end
			end
			ST_DIVV: begin
				if (div_done) begin
					mv_q <= div_quo;
				end
			end
			ST_CHG: begin
				vmax_q <= bvg_pkg::MV_W'(cfg.cell_count) * bvg_pkg::MV_W'(full_cell);
				vmin_q <= bvg_pkg::MV_W'(cfg.cell_count) * bvg_pkg::MV_W'(empty_cell);
				span_q <= bvg_pkg::SPAN_W'(cfg.cell_count) * bvg_pkg::SPAN_W'(span_cell);
			end
			ST_DEC: begin
				if (mv_q == '0) begin
					chg_q <= '0;
				end else if (mv_q <= vmin_q) begin
					// no span (zero cells): any nonzero voltage reads full
					chg_q <= (span_q == '0) ? bvg_pkg::CHARGE_FULL : '0;
				end else if (mv_q >= vmax_q) begin
					chg_q <= bvg_pkg::CHARGE_FULL;
				end else begin
					prod_q <= bvg_pkg::PROD_W'(mv_q - vmin_q) *
						bvg_pkg::PROD_W'(bvg_pkg::CHARGE_FULL);
				end
			end
			ST_DIVC: begin
				if (div_done) begin
					chg_q <= div_quo[bvg_pkg::CHARGE_W-1:0];
				end
			end
			ST_DONE: begin
				if (out_free) begin
					battery_mv_q <= mv_q;
					charge_q     <= chg_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid           = out_valid_q;
	assign battery_mv          = battery_mv_q;
	assign charge_centipercent = charge_q;

endmodule

// ----- design/battery_voltage_gauge.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_voltage_gauge
// Moving-average battery voltage and state-of-charge gauge.
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid/in_ready    sample_mv
//  out      out_valid/out_ready  battery_mv, charge_centipercent
//  cfg      cfg_valid/cfg_ready  cfg_index, cfg_data (cfg_ready always high)
//
//  An enabled item with a nonzero sum makes two passes through the back
//  end's shared 17-step divider, unless its voltage saturates or its charge
//  clamps. Disabled items and zero sums skip the divider, a saturated
//  voltage makes no division and a clamped charge one. The front end holds
//  one beat and takes the next once that one is pushed and the two-entry
//  queue has room; the back end keeps working while a result waits in the
//  output register. Reset zeroes the ring by a wrap flag: no clearing pass.
// ----------------------------------------------------------------------------
module battery_voltage_gauge #(
	parameter int AVERAGE_DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [bvg_pkg::SAMPLE_W-1:0]     sample_mv,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [bvg_pkg::MV_W-1:0]         battery_mv,
	output logic [bvg_pkg::CHARGE_W-1:0]     charge_centipercent,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [bvg_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bvg_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int SUM_W = $clog2(AVERAGE_DEPTH*(2**bvg_pkg::SAMPLE_W-1)+1);

	bvg_pkg::bvg_cfg_t cfg_q;
	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_empty;
	logic [SUM_W:0]    q_wdata;
	logic [SUM_W:0]    q_rdata;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled    <= 1'b0;
			cfg_q.upper_ohms <= bvg_pkg::UPPER_RESET;
			cfg_q.lower_ohms <= bvg_pkg::LOWER_RESET;
			cfg_q.chemistry  <= bvg_pkg::CHEM_LIPO;
			cfg_q.cell_count <= bvg_pkg::CELLS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				bvg_pkg::REG_ENABLED: cfg_q.enabled    <= cfg_data[0];
				bvg_pkg::REG_UPPER:   cfg_q.upper_ohms <= cfg_data[bvg_pkg::RES_W-1:0];
				bvg_pkg::REG_LOWER:   cfg_q.lower_ohms <= cfg_data[bvg_pkg::RES_W-1:0];
				bvg_pkg::REG_CHEM:    cfg_q.chemistry  <= cfg_data[0];
				bvg_pkg::REG_CELLS:   cfg_q.cell_count <= cfg_data[bvg_pkg::CELL_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bvg_front #(
		.AVERAGE_DEPTH(AVERAGE_DEPTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sample_mv(sample_mv),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata)
	);

	bvg_queue #(
		.WIDTH(SUM_W + 1)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_data(q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.pop_data (q_rdata),
		.empty    (q_empty)
	);

	bvg_back #(
		.AVERAGE_DEPTH(AVERAGE_DEPTH)
	) u_back (
		.clk                (clk),
		.arst_n             (arst_n),
		.cfg                (cfg_q),
		.q_empty            (q_empty),
		.q_pop              (q_pop),
		.q_data             (q_rdata),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.battery_mv         (battery_mv),
		.charge_centipercent(charge_centipercent)
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue pushed while full");

	a_zero_mv_zero_charge: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (battery_mv == '0)) |-> (charge_centipercent == '0))
		else $error("charge nonzero at zero voltage");

	a_charge_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (charge_centipercent <= bvg_pkg::CHARGE_FULL))
		else $error("charge above full scale");

endmodule
